// ===== hdl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdspi_pkg;

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  // Response kinds of a command
  localparam logic [3:0] RK_NONE = 4'd0;
  localparam logic [3:0] RK_R1   = 4'd1;
  localparam logic [3:0] RK_R1B  = 4'd2;
  localparam logic [3:0] RK_R2   = 4'd3;
  localparam logic [3:0] RK_R3   = 4'd4;
  localparam logic [3:0] RK_R7   = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  // Transfer phases
  localparam logic [3:0] PH_IDLE            = 4'd0;
  localparam logic [3:0] PH_WAIT_R1         = 4'd1;
  localparam logic [3:0] PH_WAIT_R1B        = 4'd2;
  localparam logic [3:0] PH_WAIT_REG_TOKEN  = 4'd3;
  localparam logic [3:0] PH_REG_BYTES       = 4'd4;
  localparam logic [3:0] PH_REG_CRC         = 4'd5;
  localparam logic [3:0] PH_WORD_BYTES      = 4'd6;
  localparam logic [3:0] PH_WAIT_DATA_TOKEN = 4'd7;
  localparam logic [3:0] PH_DATA            = 4'd8;
  localparam logic [3:0] PH_DATA_CRC        = 4'd9;

  // Bus bytes and command numbers
  localparam logic [7:0] BYTE_FILL  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_CSD = 6'd9;
  localparam logic [9:0] POLL_LIMIT_RESET = 10'd999;
  localparam logic [6:0] CRC7_POLY = 7'h09;

  typedef struct packed {
    logic        opcode;
    logic        has_command;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [3:0]  resp_kind;
    logic        data_read;
    logic [15:0] data_length;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic        chip_select;
    logic        success;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        last;
  } rsp_t;

  // Advance CRC-7 (x^7+x^3+1) over one byte, msb first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb = c[6] ^ b[k];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sdspi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sdspi_req_if import sdspi_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sd_spi_command_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SD card command engine, SPI mode, host side. A start item selects the card and
// produces the command frame (0x40|index, argument msb first, CRC-7 with end bit),
// preceded by IDLE_BYTES deselected 0xFF bytes for command 0. Each received byte
// from the card is then fed in as an item; the engine polls for R1/R1b, collects
// R3/R7 and CID/CSD words, passes read data bytes on and ends a transfer with a
// deselected 0xFF and a finish item carrying success and the response words.
// Results leave one per cycle, unless stalled, through an output register. A
// received byte makes no result, a data byte, or a deselected 0xFF and a finish;
// a start with a command makes the frame, after the 0xFF bytes for command 0,
// plus the 0xFF and finish when it finishes at once; a start without a command
// makes these two only when it finishes at once. The CRC-7 register advances one
// frame byte per cycle, unless stalled, as the frame goes out. poll_limit must be
// written only while the block is idle (not enforced); zero counts as one try.
module sd_spi_command_engine_core import sdspi_pkg::*; #(
  parameter int IDLE_BYTES = 10
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata,
  sdspi_req_if.sink       req,
  sdspi_rsp_if.source     rsp
);

  localparam int SW = $clog2(IDLE_BYTES + 9);

  // Item holding register and result step
  req_t          hold;
  logic          hold_valid;
  logic [SW-1:0] step;

  // Transfer state
  logic [9:0]  poll_limit;
  logic [3:0]  phase;
  logic [9:0]  poll_count;
  logic [15:0] byte_count;
  logic [31:0] resp_word [4];
  logic        ok_flag;
  logic [5:0]  held_index;
  logic [3:0]  held_kind;
  logic        held_read;
  logic [15:0] held_length;
  logic [6:0]  crc;

  logic [3:0]  phase_next;
  logic [9:0]  poll_count_next;
  logic [15:0] byte_count_next;
  logic [31:0] resp_word_next [4];
  logic        ok_flag_next;
  logic [5:0]  held_index_next;
  logic [3:0]  held_kind_next;
  logic        held_read_next;
  logic [15:0] held_length_next;

  // Result plan for the held item
  logic [SW-1:0] n_idle;
  logic [2:0]    n_frame;
  logic          n_data;
  logic          fin;
  logic          cmd_done;
  logic          fin_now;
  logic [9:0]    lim;
  logic [10:0]   poll_inc;
  logic          try_fail;
  logic [15:0]   byte_inc;

  // Output register
  rsp_t out_q;
  logic out_valid;

  // Work out next state and result plan of the held item
  always_comb begin
    phase_next       = phase;
    poll_count_next  = poll_count;
    byte_count_next  = byte_count;
    resp_word_next   = resp_word;
    ok_flag_next     = ok_flag;
    held_index_next  = held_index;
    held_kind_next   = held_kind;
    held_read_next   = held_read;
    held_length_next = held_length;
    n_idle           = '0;
    n_frame          = 3'd0;
    n_data           = 1'b0;
    fin              = 1'b0;
    cmd_done         = 1'b0;
    fin_now          = 1'b0;
    lim              = (poll_limit == 10'd0) ? 10'd1 : poll_limit;
    poll_inc         = {1'b0, poll_count} + 11'd1;
    try_fail         = poll_inc >= {1'b0, lim};
    byte_inc         = byte_count + 16'd1;

    if (hold.opcode == OP_START) begin
      held_index_next  = hold.cmd_index;
      held_kind_next   = hold.resp_kind;
      held_read_next   = hold.data_read;
      held_length_next = hold.data_length;
      for (int i = 0; i < 4; i++) begin
        resp_word_next[i] = '0;
      end
      ok_flag_next    = 1'b0;
      poll_count_next = '0;
      byte_count_next = '0;
      if (!hold.has_command) begin
        cmd_done = 1'b1;
      end else begin
        n_idle  = (hold.cmd_index == CMD_GO_IDLE) ? SW'(IDLE_BYTES) : '0;
        n_frame = 3'd6;
        if (hold.resp_kind == RK_R1 || hold.resp_kind == RK_R2 ||
            hold.resp_kind == RK_R3 || hold.resp_kind == RK_R7) begin
          phase_next = PH_WAIT_R1;
        end else if (hold.resp_kind == RK_R1B) begin
          phase_next = PH_WAIT_R1B;
        end else begin
          cmd_done = 1'b1;
        end
      end
    end else begin
      unique case (phase)
        PH_WAIT_R1: begin
          if (!hold.rx_byte[7]) begin
            poll_count_next = '0;
            if (held_kind == RK_R1 &&
                (held_index == CMD_SEND_CID || held_index == CMD_SEND_CSD)) begin
              phase_next = PH_WAIT_REG_TOKEN;
            end else if (held_kind == RK_R3 || held_kind == RK_R7) begin
              byte_count_next = '0;
              phase_next      = PH_WORD_BYTES;
            end else begin
              ok_flag_next = 1'b1;
              cmd_done     = 1'b1;
            end
          end else begin
            poll_count_next = try_fail ? 10'd0 : poll_inc[9:0];
            cmd_done        = try_fail;
          end
        end
        PH_WAIT_R1B: begin
          if (hold.rx_byte == 8'd0) begin
            ok_flag_next = 1'b1;
            cmd_done     = 1'b1;
          end else begin
            poll_count_next = try_fail ? 10'd0 : poll_inc[9:0];
            cmd_done        = try_fail;
          end
        end
        PH_WAIT_REG_TOKEN: begin
          if (hold.rx_byte == BYTE_TOKEN) begin
            poll_count_next = '0;
            byte_count_next = '0;
            phase_next      = PH_REG_BYTES;
          end else begin
            poll_count_next = try_fail ? 10'd0 : poll_inc[9:0];
            cmd_done        = try_fail;
          end
        end
        PH_REG_BYTES: begin
          resp_word_next[byte_count[3:2]] =
            {resp_word[byte_count[3:2]][23:0], hold.rx_byte};
          byte_count_next = byte_inc;
          if (byte_inc >= 16'd16) begin
            byte_count_next = '0;
            phase_next      = PH_REG_CRC;
          end
        end
        PH_REG_CRC: begin
          byte_count_next = byte_inc;
          if (byte_inc >= 16'd2) begin
            ok_flag_next = 1'b1;
            cmd_done     = 1'b1;
          end
        end
        PH_WORD_BYTES: begin
          resp_word_next[0] = {resp_word[0][23:0], hold.rx_byte};
          byte_count_next   = byte_inc;
          if (byte_inc >= 16'd4) begin
            ok_flag_next = 1'b1;
            cmd_done     = 1'b1;
          end
        end
        PH_WAIT_DATA_TOKEN: begin
          if (hold.rx_byte == BYTE_TOKEN) begin
            poll_count_next = '0;
            byte_count_next = '0;
            phase_next      = (held_length != 16'd0) ? PH_DATA : PH_DATA_CRC;
          end else begin
            poll_count_next = try_fail ? 10'd0 : poll_inc[9:0];
            fin_now         = try_fail;
          end
        end
        PH_DATA: begin
          n_data          = 1'b1;
          byte_count_next = byte_inc;
          if (byte_inc >= held_length) begin
            byte_count_next = '0;
            phase_next      = PH_DATA_CRC;
          end
        end
        PH_DATA_CRC: begin
          byte_count_next = byte_inc;
          if (byte_inc >= 16'd2) begin
            ok_flag_next = 1'b1;
            fin_now      = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // Close the command part: go on to the read phase or finish
    if (cmd_done) begin
      poll_count_next = '0;
      byte_count_next = '0;
      if (held_read_next) begin
        phase_next = PH_WAIT_DATA_TOKEN;
      end else begin
        fin_now = 1'b1;
      end
    end
    if (fin_now) begin
      fin        = 1'b1;
      phase_next = PH_IDLE;
    end
  end

  // Pick the result at the current step
  logic [SW-1:0] total;
  logic [SW-1:0] fidx;
  logic [SW-1:0] didx;
  logic [SW-1:0] eidx;
  logic          frame_upd;
  rsp_t          gen;

  always_comb begin
    total     = n_idle + SW'(n_frame) + SW'(n_data) + (fin ? SW'(2) : SW'(0));
    fidx      = step - n_idle;
    didx      = fidx - SW'(n_frame);
    eidx      = didx - SW'(n_data);
    frame_upd = 1'b0;
    gen       = '0;
    if (step < n_idle) begin
      gen.kind       = KIND_TX;
      gen.byte_value = BYTE_FILL;
    end else if (fidx < SW'(n_frame)) begin
      gen.kind        = KIND_TX;
      gen.chip_select = 1'b1;
      frame_upd       = (fidx < SW'(5));
      unique case (fidx[2:0])
        3'd0:    gen.byte_value = {2'b01, hold.cmd_index};
        3'd1:    gen.byte_value = hold.cmd_arg[31:24];
        3'd2:    gen.byte_value = hold.cmd_arg[23:16];
        3'd3:    gen.byte_value = hold.cmd_arg[15:8];
        3'd4:    gen.byte_value = hold.cmd_arg[7:0];
        default: gen.byte_value = {crc, 1'b1};
      endcase
    end else if (didx < SW'(n_data)) begin
      gen.kind        = KIND_DATA;
      gen.byte_value  = hold.rx_byte;
      gen.chip_select = 1'b1;
    end else if (eidx == '0) begin
      gen.kind       = KIND_TX;
      gen.byte_value = BYTE_FILL;
    end else begin
      gen.kind       = KIND_FIN;
      gen.success    = ok_flag_next;
      gen.resp_word0 = resp_word_next[0];
      gen.resp_word1 = resp_word_next[1];
      gen.resp_word2 = resp_word_next[2];
      gen.resp_word3 = resp_word_next[3];
    end
    gen.last = (step == total - SW'(1));
  end

  // Handshake control
  logic gen_valid;
  logic load;
  logic done;
  logic accept;

  assign gen_valid = hold_valid && (total != '0);
  assign load      = gen_valid && (!out_valid || rsp.ready);
  assign done      = hold_valid && ((total == '0) || (load && gen.last));
  assign req.ready = !hold_valid || done;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // Hold the item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= req.data;
    end
  end

  // Drive the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= gen;
    end
  end

  // Advance control and commit state when an item is done
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit  <= POLL_LIMIT_RESET;
      hold_valid  <= 1'b0;
      step        <= '0;
      out_valid   <= 1'b0;
      crc         <= '0;
      phase       <= PH_IDLE;
      poll_count  <= '0;
      byte_count  <= '0;
      ok_flag     <= 1'b0;
      held_index  <= '0;
      held_kind   <= '0;
      held_read   <= 1'b0;
      held_length <= '0;
      for (int i = 0; i < 4; i++) begin
        resp_word[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        poll_limit <= cfg_wdata;
      end
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (done) begin
        hold_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (done) begin
        step        <= '0;
        crc         <= '0;
        phase       <= phase_next;
        poll_count  <= poll_count_next;
        byte_count  <= byte_count_next;
        ok_flag     <= ok_flag_next;
        held_index  <= held_index_next;
        held_kind   <= held_kind_next;
        held_read   <= held_read_next;
        held_length <= held_length_next;
        resp_word   <= resp_word_next;
      end else if (load) begin
        step <= step + SW'(1);
        if (frame_upd) begin
          crc <= crc7_byte(crc, gen.byte_value);
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Status fields stay clear on every result other than the finish
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.kind != KIND_FIN |->
      !rsp.data.success && rsp.data.resp_word0 == '0 && rsp.data.resp_word3 == '0)
    else $error("status set on a non-finish result");

  // Input is held off only while an item is being worked
  assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> hold_valid)
    else $error("ready low with no item held");

  // No poll count survives into idle
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> poll_count == '0)
    else $error("poll count left over in idle");

  // CRC register starts clean for every item
  assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> crc == '0)
    else $error("CRC not cleared between items");
`endif

endmodule

`default_nettype wire
